// File: sv/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types and constants of the ranking inversion distance block.
// ----------------------------------------------------------------------------
package rid_pkg;

  // Default sizes: longest ranking and number of table entries
  localparam int MAX_LENGTH_DEF = 64;
  localparam int ID_COUNT_DEF   = 1024;

  // Fixed field widths
  localparam int ID_W      = 10;
  localparam int COUNT_W   = 11;
  localparam int STATUS_W  = 3;
  localparam int COUNT_MAX = 2047;

  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  // Table entry tag: one mark per reference, the table is swept when it wraps
  localparam int EPOCH_W = 8;

  // Popcount tree: bits per group, groups per super group
  localparam int GROUP_W  = 8;
  localparam int SUPER_N  = 8;
  localparam int GCNT_W   = 4;
  localparam int SUPER_W  = 7;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_MISSING  = 3'd1,
    STAT_REPEAT   = 3'd2,
    STAT_LONG     = 3'd3,
    STAT_MISMATCH = 3'd4
  } status_e;

  typedef enum logic {
    S_SWEEP = 1'b0,
    S_RUN   = 1'b1
  } ctrl_state_e;

  // Per item event passed from the lookup stage to the count pipeline
  typedef struct packed {
    logic    valid;
    logic    clr;
    logic    emit;
    status_e status;
  } evt_t;

endpackage

// File: sv/rid_table.sv
// ----------------------------------------------------------------------------
// rid_table
// Id-to-position table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rid_table #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Read returns the old value when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/rid_ctrl.sv
// ----------------------------------------------------------------------------
// rid_ctrl
// Lookup stage: resolves each item against the table, keeps the reference and
// candidate state, writes first occurrences and sweeps the table when needed.
// ----------------------------------------------------------------------------
module rid_ctrl #(
  parameter int MAX_LENGTH = rid_pkg::MAX_LENGTH_DEF,
  parameter int ID_COUNT   = rid_pkg::ID_COUNT_DEF,
  parameter int ADDR_W     = $clog2(ID_COUNT),
  parameter int ENT_W      = rid_pkg::EPOCH_W + $clog2(MAX_LENGTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic [rid_pkg::ID_W-1:0] s_id_i,
  input  logic                    s_ref_i,
  input  logic                    s_last_i,
  input  logic                    en_i,
  output logic                    s_tready_o,
  output logic                    tbl_we_o,
  output logic [ADDR_W-1:0]       tbl_waddr_o,
  output logic [ENT_W-1:0]        tbl_wdata_o,
  output logic                    tbl_re_o,
  output logic [ADDR_W-1:0]       tbl_raddr_o,
  input  logic [ENT_W-1:0]        tbl_rdata_i,
  output rid_pkg::evt_t           evt_o,
  output logic [MAX_LENGTH-1:0]   vec_o
);
  import rid_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH);
  localparam int LEN_W = $clog2(MAX_LENGTH + 2);
  localparam logic [ADDR_W-1:0]  SWEEP_LAST = ADDR_W'(ID_COUNT - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_TOP  = {EPOCH_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(MAX_LENGTH);
  localparam logic [LEN_W-1:0]   LEN_OVER   = LEN_W'(MAX_LENGTH + 1);

  function automatic status_e set_err(status_e cur, status_e code);
    return (cur == STAT_OK) ? code : cur;
  endfunction

  ctrl_state_e            state_q, state_d;
  logic [ADDR_W-1:0]      sweep_q, sweep_d;
  logic [EPOCH_W-1:0]     epoch_q, epoch_d;
  logic                   ref_open_q, ref_open_d;
  logic [LEN_W-1:0]       ref_len_q, ref_len_d;
  logic [LEN_W-1:0]       cand_len_q, cand_len_d;
  status_e                err_q, err_d;
  logic [MAX_LENGTH-1:0]  seen_q, seen_d;

  // Item held in the lookup stage
  logic                   b_vld_q;
  logic [ID_W-1:0]        b_id_q;
  logic                   b_ref_q;
  logic                   b_last_q;

  // Last table write, for an item whose read overlapped it
  logic                   fwd_vld_q, fwd_vld_d;
  logic [ADDR_W-1:0]      fwd_addr_q, fwd_addr_d;
  logic [ENT_W-1:0]       fwd_data_q, fwd_data_d;

  logic                   ready;
  logic                   accept;
  logic                   need_wrap;
  logic [ADDR_W-1:0]      b_addr;
  logic                   in_range;
  logic [ENT_W-1:0]       ent;
  logic [EPOCH_W-1:0]     ent_ep;
  logic [POS_W-1:0]       ent_pos;
  logic                   hit;
  logic                   start;
  logic [EPOCH_W-1:0]     ep_new;
  logic [LEN_W-1:0]       len_base;
  logic [LEN_W-1:0]       cl_n;
  status_e                err_n;
  logic [MAX_LENGTH-1:0]  seen_n;

  assign b_addr    = ADDR_W'(b_id_q);
  assign in_range  = int'(b_id_q) < ID_COUNT;
  assign ent       = (fwd_vld_q && (fwd_addr_q == b_addr)) ? fwd_data_q : tbl_rdata_i;
  assign ent_ep    = ent[ENT_W-1:POS_W];
  assign ent_pos   = ent[POS_W-1:0];
  assign hit       = in_range && (ent_ep == epoch_q) && (epoch_q != '0);
  assign start     = !ref_open_q;
  assign need_wrap = b_vld_q && b_ref_q && start && (epoch_q == EPOCH_TOP);

  assign ready       = en_i && (state_q == S_RUN) && !need_wrap;
  assign accept      = s_tvalid_i && ready;
  assign s_tready_o  = ready;
  assign tbl_re_o    = accept;
  assign tbl_raddr_o = ADDR_W'(s_id_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SWEEP;
      sweep_q    <= '0;
      epoch_q    <= '0;
      ref_open_q <= 1'b0;
      ref_len_q  <= '0;
      cand_len_q <= '0;
      err_q      <= STAT_OK;
      seen_q     <= '0;
      b_vld_q    <= 1'b0;
      fwd_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      epoch_q    <= epoch_d;
      ref_open_q <= ref_open_d;
      ref_len_q  <= ref_len_d;
      cand_len_q <= cand_len_d;
      err_q      <= err_d;
      seen_q     <= seen_d;
      fwd_vld_q  <= fwd_vld_d;
      if (ready) begin
        b_vld_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_id_q   <= s_id_i;
      b_ref_q  <= s_ref_i;
      b_last_q <= s_last_i;
    end
    fwd_addr_q <= fwd_addr_d;
    fwd_data_q <= fwd_data_d;
  end

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    epoch_d     = epoch_q;
    ref_open_d  = ref_open_q;
    ref_len_d   = ref_len_q;
    cand_len_d  = cand_len_q;
    err_d       = err_q;
    seen_d      = seen_q;
    fwd_vld_d   = fwd_vld_q;
    fwd_addr_d  = fwd_addr_q;
    fwd_data_d  = fwd_data_q;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = b_addr;
    tbl_wdata_o = '0;
    evt_o       = '0;
    vec_o       = '0;
    ep_new      = epoch_q;
    len_base    = ref_len_q;
    cl_n        = cand_len_q;
    err_n       = err_q;
    seen_n      = seen_q;

    unique case (state_q)
      S_SWEEP: begin
        tbl_we_o    = 1'b1;
        tbl_waddr_o = sweep_q;
        fwd_vld_d   = 1'b0;
        if (sweep_q == SWEEP_LAST) begin
          state_d = S_RUN;
          sweep_d = '0;
          epoch_d = '0;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_RUN: begin
        if (need_wrap) begin
          // hold the item until every tag is back to zero
          state_d = S_SWEEP;
        end else if (ready) begin
          fwd_vld_d = 1'b0;
          if (b_vld_q) begin
            evt_o.valid = 1'b1;
            if (b_ref_q) begin
              if (start) begin
                seen_d     = '0;
                cand_len_d = '0;
                err_d      = STAT_OK;
                evt_o.clr  = 1'b1;
                ep_new     = epoch_q + 1'b1;
                len_base   = '0;
              end
              if (len_base < LEN_MAX) begin
                // keep the first occurrence of an id
                if (in_range && (start || !hit)) begin
                  tbl_we_o    = 1'b1;
                  tbl_waddr_o = b_addr;
                  tbl_wdata_o = {ep_new, POS_W'(len_base)};
                  fwd_vld_d   = 1'b1;
                  fwd_addr_d  = b_addr;
                  fwd_data_d  = {ep_new, POS_W'(len_base)};
                end
                ref_len_d = len_base + 1'b1;
              end else begin
                ref_len_d = LEN_OVER;
              end
              epoch_d    = ep_new;
              ref_open_d = !b_last_q;
            end else begin
              ref_open_d = 1'b0;
              if (cand_len_q >= LEN_MAX) begin
                err_n = set_err(err_n, STAT_LONG);
              end else begin
                cl_n = cand_len_q + 1'b1;
                if (!hit) begin
                  err_n = set_err(err_n, STAT_MISSING);
                end else if (seen_q[ent_pos]) begin
                  err_n = set_err(err_n, STAT_REPEAT);
                end else begin
                  for (int q = 0; q < MAX_LENGTH; q++) begin
                    vec_o[q] = seen_q[q] && (q > int'(ent_pos));
                  end
                  seen_n[ent_pos] = 1'b1;
                end
              end
              if (b_last_q) begin
                if (ref_len_q > LEN_MAX) begin
                  err_n = set_err(err_n, STAT_LONG);
                end
                if (ref_len_q != cl_n) begin
                  err_n = set_err(err_n, STAT_MISMATCH);
                end
                evt_o.emit   = 1'b1;
                evt_o.status = err_n;
                seen_d       = '0;
                cand_len_d   = '0;
                err_d        = STAT_OK;
              end else begin
                seen_d     = seen_n;
                cand_len_d = cl_n;
                err_d      = err_n;
              end
            end
          end
        end
      end
    endcase
  end

  a_accept_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == S_RUN))
    else $error("item accepted during table sweep");

  a_sweep_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && sweep_q == SWEEP_LAST) |=> (state_q == S_RUN && epoch_q == '0))
    else $error("sweep did not end with tag zero");

  a_write_ref : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && tbl_we_o) |-> (b_vld_q && b_ref_q && !need_wrap))
    else $error("table written by something other than a reference item");

  a_open_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_open_q |-> (epoch_q != '0))
    else $error("open reference carries tag zero");

endmodule

// File: sv/rid_count.sv
// ----------------------------------------------------------------------------
// rid_count
// Count pipeline: registered popcount tree over the later-position flags and
// the saturating running count; forms one result per finished candidate.
// ----------------------------------------------------------------------------
module rid_count #(
  parameter int MAX_LENGTH = rid_pkg::MAX_LENGTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  rid_pkg::evt_t               evt_i,
  input  logic [MAX_LENGTH-1:0]       vec_i,
  output logic                        push_o,
  output logic [rid_pkg::COUNT_W-1:0] push_count_o,
  output rid_pkg::status_e            push_status_o
);
  import rid_pkg::*;

  localparam int NGROUP = (MAX_LENGTH + GROUP_W - 1) / GROUP_W;
  localparam int NSUPER = (NGROUP + SUPER_N - 1) / SUPER_N;
  localparam int VEC_W  = NGROUP * GROUP_W;
  localparam int SUM_W  = COUNT_W + 1;

  evt_t               s1_evt_q, s2_evt_q, s3_evt_q;
  logic [VEC_W-1:0]   s1_vec_q;
  logic [GCNT_W-1:0]  s2_cnt_q [NGROUP];
  logic [SUPER_W-1:0] s3_sum_q [NSUPER];
  logic [COUNT_W-1:0] acc_q, acc_d;

  logic [GCNT_W-1:0]  grp_cnt [NGROUP];
  logic [GCNT_W-1:0]  grp_pad [NSUPER*SUPER_N];
  logic [SUPER_W-1:0] sup_sum [NSUPER];
  logic [SUM_W-1:0]   total;
  logic [COUNT_W-1:0] sat;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < GROUP_W; b++) begin
        grp_cnt[g] = grp_cnt[g] + GCNT_W'(s1_vec_q[g*GROUP_W + b]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NSUPER*SUPER_N; k++) begin
      grp_pad[k] = (k < NGROUP) ? s2_cnt_q[k] : '0;
    end
    for (int s = 0; s < NSUPER; s++) begin
      sup_sum[s] = '0;
      for (int k = 0; k < SUPER_N; k++) begin
        sup_sum[s] = sup_sum[s] + SUPER_W'(grp_pad[s*SUPER_N + k]);
      end
    end
  end

  // Add this item's later count; a reference start clears the count first
  always_comb begin
    total = s3_evt_q.clr ? '0 : SUM_W'(acc_q);
    for (int s = 0; s < NSUPER; s++) begin
      total = total + SUM_W'(s3_sum_q[s]);
    end
    sat = (total > SUM_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : total[COUNT_W-1:0];
    acc_d = acc_q;
    if (en_i && s3_evt_q.valid) begin
      acc_d = s3_evt_q.emit ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_evt_q <= '0;
      s2_evt_q <= '0;
      s3_evt_q <= '0;
      acc_q    <= '0;
    end else begin
      acc_q <= acc_d;
      if (en_i) begin
        s1_evt_q <= evt_i;
        s2_evt_q <= s1_evt_q;
        s3_evt_q <= s2_evt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_vec_q <= VEC_W'(vec_i);
      s2_cnt_q <= grp_cnt;
      s3_sum_q <= sup_sum;
    end
  end

  assign push_o        = en_i && s3_evt_q.valid && s3_evt_q.emit;
  assign push_count_o  = (s3_evt_q.status == STAT_OK) ? sat : '0;
  assign push_status_o = s3_evt_q.status;

endmodule

// File: sv/rid_outbuf.sv
// ----------------------------------------------------------------------------
// rid_outbuf
// Two-entry result buffer between the count pipeline and the output channel.
// ----------------------------------------------------------------------------
module rid_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [rid_pkg::COUNT_W-1:0] push_count_i,
  input  rid_pkg::status_e            push_status_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [rid_pkg::COUNT_W-1:0] m_count_o,
  output rid_pkg::status_e            m_status_o,
  output logic                        en_o
);
  import rid_pkg::*;

  logic [COUNT_W-1:0] cnt_mem_q [2];
  status_e            st_mem_q  [2];
  logic               wptr_q;
  logic               rptr_q;
  logic [1:0]         fill_q, fill_d;
  logic               pop;

  assign m_tvalid_o = (fill_q != 2'd0);
  assign pop        = m_tvalid_o && m_tready_i;
  assign en_o       = (fill_q != 2'd2);
  assign m_count_o  = cnt_mem_q[rptr_q];
  assign m_status_o = st_mem_q[rptr_q];

  always_comb begin
    fill_d = fill_q;
    case ({push_i, pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cnt_mem_q[wptr_q] <= push_count_i;
      st_mem_q[wptr_q]  <= push_status_i;
    end
  end

endmodule

// File: sv/ranking_inversion_distance.sv
// ----------------------------------------------------------------------------
// ranking_inversion_distance
// Kendall tau distance: inversion count of a candidate ranking against a
// stored reference ranking.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tdata carries the item id, tuser
// says whether the item belongs to the reference (1) or the candidate (0) and
// tlast marks the final item of a ranking. A reference item after a closed
// reference starts a new one. The m_axis channel carries one result for each
// candidate item with tlast set: the inversion count and a status.
// Throughput is one item per clock outside table sweeps and while the result
// buffer has room, set by the single read port of the id-to-position table;
// the table read for an item is issued when the item is taken. A result passes
// through the lookup stage, the count pipeline and the result buffer to m_axis.
// After reset the table is swept, one entry a cycle, with s_axis_tready low.
// Each reference tags its entries with an 8-bit mark; when the mark wraps, after
// 255 references, the start of the next reference holds the input while the
// table is swept again. A two-entry result buffer lets items keep flowing while
// a result waits; s_axis_tready also drops when both entries are occupied.
// ----------------------------------------------------------------------------
module ranking_inversion_distance #(
  parameter int MAX_LENGTH = rid_pkg::MAX_LENGTH_DEF,
  parameter int ID_COUNT   = rid_pkg::ID_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rid_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [9:0] item_id
  input  logic [0:0]                    s_axis_tuser,  // [0] is_reference
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rid_pkg::M_TDATA_W-1:0] m_axis_tdata   // [10:0] inversion_count,
                                                       // [13:11] status
);
  import rid_pkg::*;

  localparam int ADDR_W = $clog2(ID_COUNT);
  localparam int ENT_W  = EPOCH_W + $clog2(MAX_LENGTH);

  logic                  en;
  logic                  tbl_we;
  logic [ADDR_W-1:0]     tbl_waddr;
  logic [ENT_W-1:0]      tbl_wdata;
  logic                  tbl_re;
  logic [ADDR_W-1:0]     tbl_raddr;
  logic [ENT_W-1:0]      tbl_rdata;
  evt_t                  evt;
  logic [MAX_LENGTH-1:0] vec;
  logic                  push;
  logic [COUNT_W-1:0]    push_count;
  status_e               push_status;
  logic [COUNT_W-1:0]    m_count;
  status_e               m_status;

  rid_table #(
    .DEPTH  (ID_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (ENT_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  rid_ctrl #(
    .MAX_LENGTH (MAX_LENGTH),
    .ID_COUNT   (ID_COUNT),
    .ADDR_W     (ADDR_W),
    .ENT_W      (ENT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_id_i      (s_axis_tdata[ID_W-1:0]),
    .s_ref_i     (s_axis_tuser[0]),
    .s_last_i    (s_axis_tlast),
    .en_i        (en),
    .s_tready_o  (s_axis_tready),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_re_o    (tbl_re),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata),
    .evt_o       (evt),
    .vec_o       (vec)
  );

  rid_count #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .evt_i         (evt),
    .vec_i         (vec),
    .push_o        (push),
    .push_count_o  (push_count),
    .push_status_o (push_status)
  );

  rid_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_count_i  (push_count),
    .push_status_i (push_status),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_count_o     (m_count),
    .m_status_o    (m_status),
    .en_o          (en)
  );

  assign m_axis_tdata = {{(M_TDATA_W - COUNT_W - STATUS_W){1'b0}}, m_status, m_count};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ranking inversion distance block.
// Reference and candidate rankings go in on the input stream with random
// gaps. A local model of the id-to-position table and the candidate state
// predicts each result. Results are read back with random stalls and
// compared field by field against the predictions, in order.
// ----------------------------------------------------------------------------
module testbench;
  import rid_pkg::*;

  localparam int MAXL        = MAX_LENGTH_DEF;
  localparam int IDS         = ID_COUNT_DEF;
  localparam int WAIT_MAX    = 12;
  localparam int IDLE_LIMIT  = 5000;   // covers a full table sweep several times
  localparam int TAIL_CYCLES = 24;
  localparam int ITEM_TARGET = 1550;
  localparam int TINY_ROUNDS = 270;    // enough references to wrap the 8-bit tag

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               is_ref;
    logic               last;
    logic               typed;   // row carries a hand-written result
    logic [COUNT_W-1:0] inv;
    status_e            st;
  } rank_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] inv;
    status_e            st;
  } rank_result_t;

  // id, is_ref, last, typed, count, status
  localparam rank_item_t DIRECTED [21] = '{
    '{10'd5,    1'b0, 1'b1, 1'b1, 11'd0, STAT_MISSING},   // candidate before any reference
    '{10'd1023, 1'b1, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd0,    1'b1, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd1023, 1'b1, 1'b1, 1'b0, 11'd0, STAT_OK},        // repeat: first position kept
    '{10'd0,    1'b0, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd1023, 1'b0, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd0,    1'b0, 1'b1, 1'b1, 11'd0, STAT_REPEAT},
    '{10'd1023, 1'b0, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd0,    1'b0, 1'b1, 1'b1, 11'd0, STAT_MISMATCH},  // two items against three
    '{10'd7,    1'b1, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd300,  1'b1, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd512,  1'b1, 1'b1, 1'b0, 11'd0, STAT_OK},
    '{10'd512,  1'b0, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd300,  1'b0, 1'b0, 1'b0, 11'd0, STAT_OK},
    '{10'd7,    1'b0, 1'b1, 1'b1, 11'd3, STAT_OK},        // fully reversed
    '{10'd9,    1'b1, 1'b0, 1'b0, 11'd0, STAT_OK},        // reference left open
    '{10'd9,    1'b0, 1'b1, 1'b1, 11'd0, STAT_OK},        // candidate closes it
    '{10'd9,    1'b0, 1'b0, 1'b0, 11'd0, STAT_OK},        // candidate in progress...
    '{10'd4,    1'b1, 1'b1, 1'b0, 11'd0, STAT_OK},        // ...dropped by a new reference
    '{10'd4,    1'b0, 1'b1, 1'b1, 11'd0, STAT_OK},
    '{10'd1,    1'b0, 1'b1, 1'b1, 11'd0, STAT_MISSING}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // [9:0] item_id
  logic [0:0]           s_axis_tuser;   // [0] is_reference
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [10:0] inversion_count, [13:11] status

  always #6 clk_i = ~clk_i;

  ranking_inversion_distance uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Local ranking state
  logic [5:0]    ref_pos   [IDS];
  bit            ref_known [IDS];
  bit [MAXL-1:0] cand_seen;
  int unsigned   cand_inv;
  int unsigned   ref_len;
  int unsigned   cand_len;
  status_e       cand_err;
  bit            ref_open;

  rank_item_t   stim_q[$];
  rank_result_t expected_ranks[$];
  int           accept_idx;
  int           ranks_checked;
  int           refs_started;
  int           mismatch_count;
  int           idle_cycles;
  int           peak_inv;
  int           status_tally [5];

  function automatic void flag_error(status_e code);
    if (cand_err == STAT_OK) cand_err = code;
  endfunction

  function automatic void clear_candidate();
    cand_seen = '0;
    cand_inv  = 0;
    cand_len  = 0;
    cand_err  = STAT_OK;
  endfunction

  // Advance the ranking state by one item; return 1 when it yields a result
  function automatic bit rank_distance_step(input rank_item_t it, output rank_result_t res);
    int unsigned p;
    res = '0;
    if (it.is_ref) begin
      if (!ref_open) begin
        ref_known = '{default: 1'b0};
        ref_len   = 0;
        clear_candidate();
        ref_open  = 1'b1;
        refs_started++;
      end
      if (ref_len < MAXL) begin
        if (it.id < IDS && !ref_known[it.id]) begin
          ref_known[it.id] = 1'b1;
          ref_pos[it.id]   = ref_len[5:0];
        end
        ref_len++;
      end else begin
        ref_len = MAXL + 1;
      end
      if (it.last) ref_open = 1'b0;
      return 1'b0;
    end

    ref_open = 1'b0;
    if (cand_len >= MAXL) begin
      flag_error(STAT_LONG);
    end else begin
      cand_len++;
      if (it.id >= IDS || !ref_known[it.id]) begin
        flag_error(STAT_MISSING);
      end else begin
        p = 32'(ref_pos[it.id]);
        if (p >= MAXL || cand_seen[p]) begin
          flag_error(STAT_REPEAT);
        end else begin
          // count earlier items placed later in the reference
          cand_inv += $countones(cand_seen >> (p + 1));
          if (cand_inv > COUNT_MAX) cand_inv = COUNT_MAX;
          cand_seen[p] = 1'b1;
        end
      end
    end

    if (!it.last) return 1'b0;
    if (ref_len > MAXL) flag_error(STAT_LONG);
    if (ref_len != cand_len) flag_error(STAT_MISMATCH);
    res.inv = (cand_err == STAT_OK) ? cand_inv[COUNT_W-1:0] : '0;
    res.st  = cand_err;
    clear_candidate();
    return 1'b1;
  endfunction

  function automatic void push_item(logic [ID_W-1:0] id, bit is_ref, bit last);
    rank_item_t it;
    it        = '0;
    it.id     = id;
    it.is_ref = is_ref;
    it.last   = last;
    it.st     = STAT_OK;
    stim_q.push_back(it);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ID_W'(IDS - 1);
      default: return ID_W'($urandom_range(0, IDS - 1));
    endcase
  endfunction

  // One reference followed by candidates, mostly well formed
  function automatic void add_round(bit big);
    logic [ID_W-1:0] ids[$];
    logic [ID_W-1:0] cand[$];
    logic [ID_W-1:0] tmp;
    bit              used [IDS];
    bit              ref_last;
    bit              cand_last;
    int              len, m, n_cand, mode, j, k, s, extra;
    if (big)
      len = ($urandom_range(0, 1) == 0) ? $urandom_range(60, MAXL)
                                        : $urandom_range(MAXL + 1, MAXL + 6);
    else
      len = $urandom_range(1, 12);
    while (ids.size() < len) begin
      if (ids.size() > 0 && $urandom_range(0, 24) == 0) begin
        ids.push_back(ids[$urandom_range(0, ids.size() - 1)]);
      end else begin
        tmp = pick_id();
        if (!used[tmp]) begin
          used[tmp] = 1'b1;
          ids.push_back(tmp);
        end
      end
    end
    ref_last = ($urandom_range(0, 9) != 0);
    for (j = 0; j < len; j++)
      push_item(ids[j], 1'b1, (j == len - 1) && ref_last);

    m      = (len > MAXL) ? MAXL : len;
    n_cand = big ? 1 : $urandom_range(1, 3);
    for (k = 0; k < n_cand; k++) begin
      cand.delete();
      mode = $urandom_range(0, 99);
      if (mode < 15 || (big && $urandom_range(0, 1) == 0)) begin
        for (j = m - 1; j >= 0; j--) cand.push_back(ids[j]);
        mode = 50;
      end else begin
        for (j = 0; j < m; j++) cand.push_back(ids[j]);
        for (j = m - 1; j > 0; j--) begin
          s       = $urandom_range(0, j);
          tmp     = cand[j];
          cand[j] = cand[s];
          cand[s] = tmp;
        end
      end
      cand_last = 1'b1;
      if (mode >= 70 && mode < 78 && cand.size() > 1) begin
        cand.delete($urandom_range(0, cand.size() - 1));
      end else if (mode >= 78 && mode < 84) begin
        cand[$urandom_range(0, cand.size() - 1)] = pick_id();
      end else if (mode >= 84 && mode < 90) begin
        cand.insert($urandom_range(0, cand.size()), cand[$urandom_range(0, cand.size() - 1)]);
      end else if (mode >= 90 && mode < 96) begin
        extra = (cand.size() >= MAXL) ? $urandom_range(1, 4) : 1;
        for (j = 0; j < extra; j++) cand.push_back(pick_id());
      end else if (mode >= 96) begin
        cand_last = 1'b0;   // run into the next candidate
      end
      for (j = 0; j < cand.size(); j++)
        push_item(cand[j], 1'b0, (j == cand.size() - 1) && cand_last);
    end
  endfunction

  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) run_left = $urandom_range(16, 64);
    return $urandom_range(0, WAIT_MAX);
  endfunction

  // Result side: random stalls per result
  initial begin
    int run_left;
    int w;
    m_axis_tready <= 1'b0;
    run_left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      w = draw_wait(run_left);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
    end
  end

  // Sample both handshakes between edges; values are stable there
  always @(negedge clk_i) begin
    rank_result_t want;
    rank_result_t got;
    bit           moved;
    if (rst_ni === 1'b1) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        if (rank_distance_step(stim_q[accept_idx], want)) begin
          if (stim_q[accept_idx].typed) begin
            want.inv = stim_q[accept_idx].inv;
            want.st  = stim_q[accept_idx].st;
          end
          expected_ranks.push_back(want);
        end
        accept_idx++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved  = 1'b1;
        got.inv = m_axis_tdata[COUNT_W-1:0];
        got.st  = status_e'(m_axis_tdata[COUNT_W +: STATUS_W]);
        ranks_checked++;
        if (expected_ranks.size() == 0) begin
          $display("%0t: result with nothing pending: count %0d status %0d",
                   $time, got.inv, got.st);
          mismatch_count++;
        end else begin
          want = expected_ranks.pop_front();
          if (want.st == STAT_OK && int'(want.inv) > peak_inv) peak_inv = int'(want.inv);
          status_tally[want.st]++;
          if (got.inv !== want.inv) begin
            $display("%0t: inversion count expected %0d got %0d", $time, want.inv, got.inv);
            mismatch_count++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
            mismatch_count++;
          end
        end
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Stimulus and input side
  initial begin
    int run_left;
    int w;
    int r;
    int kind;
    logic [ID_W-1:0] tmp;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    clear_candidate();
    ref_len  = 0;
    ref_open = 1'b0;

    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    // one-item references, enough to wrap the table tag
    for (r = 0; r < TINY_ROUNDS; r++) begin
      tmp = pick_id();
      push_item(tmp, 1'b1, 1'b1);
      push_item(($urandom_range(0, 3) == 0) ? pick_id() : tmp, 1'b0, 1'b1);
    end
    while (stim_q.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        add_round(1'b1);
      end else if (kind < 94) begin
        add_round(1'b0);
      end else begin
        for (r = $urandom_range(1, 6); r > 0; r--)
          push_item(pick_id(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_left = 0;
    foreach (stim_q[i]) begin
      w = draw_wait(run_left);
      if (w > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {{(S_TDATA_W - ID_W){1'b0}}, stim_q[i].id};
      s_axis_tuser  <= stim_q[i].is_ref;
      s_axis_tlast  <= stim_q[i].last;
      do @(negedge clk_i); while (!s_axis_tready);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d items sent, %0d references, %0d results checked, peak count %0d",
             stim_q.size(), refs_started, ranks_checked, peak_inv);
    $display("statuses: ok %0d, missing %0d, repeat %0d, too long %0d, mismatch %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
sv/rid_pkg.sv
sv/rid_table.sv
sv/rid_ctrl.sv
sv/rid_count.sv
sv/rid_outbuf.sv
sv/ranking_inversion_distance.sv
tb/testbench.sv
